[rtl/assert_macros.svh]
// Assertion macros used by the decimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of aclk, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same check, but also evaluated while reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/ppcd_pkg.sv]
`timescale 1ns / 1ps
package ppcd_pkg;

    // Channel count and derived widths.
    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int FILL_W       = 8;
    localparam int FACTOR_W     = 9;
    localparam int BOUND_W      = 7;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_IDX_W    = 2;

    // Largest usable factor: the fill count holds at most 255.
    localparam logic [FACTOR_W-1:0] FACTOR_MAX = FACTOR_W'(256);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEURAL_END = 2'd0,
        REG_ANALOG_END = 2'd1,
        REG_FACTOR     = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_reg_t;

    // Channel classes as reported on the result channel.
    typedef enum logic [1:0] {
        CLASS_NEURAL  = 2'd0,
        CLASS_ANALOG  = 2'd1,
        CLASS_DIGITAL = 2'd2
    } chan_class_t;

    // One input sample.
    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       block_end;
    } in_item_t;

    // One decimated point.
    typedef struct packed {
        logic [CH_W-1:0]            out_channel;
        logic signed [SAMPLE_W-1:0] out_value;
        logic [1:0]                 channel_class;
    } out_item_t;

    // Per-channel bin state as kept in the state memory.
    typedef struct packed {
        logic [FILL_W-1:0]          fill;
        logic signed [SAMPLE_W-1:0] bin_min;
        logic signed [SAMPLE_W-1:0] bin_max;
    } bin_state_t;

endpackage

[rtl/peak_preserving_channel_decimator.sv]
`timescale 1ns / 1ps
// Channel   Ports                                   Direction  Payload
// input     s_valid, s_ready, s_data                in         in_item_t
// result    m_valid, m_ready, m_data                out        out_item_t
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in       index 2 b, data 9 b
//
// One sample is taken per cycle while the result register is not stalled; a point passes the
// input register and the result register, and the per-channel state memory read is registered.
// Reset clears the valid flags, bounds, fill valid bits and bypass, sets factor to one; no sweep.
// A stalled result register holds the pipeline; config is always taken.
`include "assert_macros.svh"

module peak_preserving_channel_decimator
    import ppcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FACTOR_W-1:0]  cfg_data
);

    // Configuration registers.
    logic [BOUND_W-1:0]  neural_end_reg;
    logic [BOUND_W-1:0]  analog_end_reg;
    logic [FACTOR_W-1:0] factor_reg;

    // Pipeline registers.
    logic                s1_valid_reg;
    in_item_t            s1_item_reg;
    bin_state_t          rd_word_reg;
    logic                out_valid_reg;
    out_item_t           out_item_reg;
    out_item_t           out_item_next;

    // State memory, its valid bits and the bypass of the last write.
    bin_state_t          state_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] entry_valid_reg;
    logic                fwd_valid_reg;
    logic [CH_W-1:0]     fwd_ch_reg;
    bin_state_t          fwd_word_reg;

    // Stage-one datapath.
    logic                s_fire;
    logic                out_load;
    logic                s1_fire;
    logic [FACTOR_W-1:0] factor_eff;
    chan_class_t         cls;
    logic                peak;
    bin_state_t          cur_word;
    bin_state_t          wr_word;
    logic [FILL_W:0]     fill_inc;
    logic                close_bin;
    logic                emit;
    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W-1:0] upd_min;
    logic signed [SAMPLE_W-1:0] upd_max;
    logic [SAMPLE_W:0]   mag_min;
    logic [SAMPLE_W:0]   mag_max;
    logic signed [SAMPLE_W-1:0] peak_value;

    assign cfg_ready = 1'b1;
    assign out_load  = !out_valid_reg || m_ready;
    assign s1_fire   = s1_valid_reg && out_load;
    assign s_ready   = !s1_valid_reg || out_load;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neural_end_reg <= '0;
            analog_end_reg <= '0;
            factor_reg     <= FACTOR_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NEURAL_END: neural_end_reg <= cfg_data[BOUND_W-1:0];
                REG_ANALOG_END: analog_end_reg <= cfg_data[BOUND_W-1:0];
                REG_FACTOR:     factor_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: a transfer loads the sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg <= s_data;
        end
    end

    // State memory: the read is issued with the transfer, the write comes from stage one.
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            state_mem[s1_item_reg.channel] <= wr_word;
        end
        if (s_fire) begin
            rd_word_reg <= state_mem[s_data.channel];
        end
    end

    // Fill valid bits and the bypass for a read that raced the last write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end else if (s1_fire) begin
            entry_valid_reg[s1_item_reg.channel] <= 1'b1;
            fwd_valid_reg                        <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            fwd_ch_reg   <= s1_item_reg.channel;
            fwd_word_reg <= wr_word;
        end
    end

    // Effective factor and the channel class.
    always_comb begin
        if (factor_reg == '0) begin
            factor_eff = FACTOR_W'(1);
        end else if (factor_reg > FACTOR_MAX) begin
            factor_eff = FACTOR_MAX;
        end else begin
            factor_eff = factor_reg;
        end
        if ({1'b0, s1_item_reg.channel} < neural_end_reg) begin
            cls = CLASS_NEURAL;
        end else if ({1'b0, s1_item_reg.channel} < analog_end_reg) begin
            cls = CLASS_ANALOG;
        end else begin
            cls = CLASS_DIGITAL;
        end
        peak = (cls == CLASS_NEURAL) && (factor_eff > FACTOR_W'(1));
    end

    // Current bin state: the newest write wins, an unwritten entry reads as an empty bin.
    always_comb begin
        if (fwd_valid_reg && (fwd_ch_reg == s1_item_reg.channel)) begin
            cur_word = fwd_word_reg;
        end else begin
            cur_word = rd_word_reg;
            if (!entry_valid_reg[s1_item_reg.channel]) begin
                cur_word.fill = '0;
            end
        end
    end

    // Extreme tracking, bin closing and the point to emit.
    always_comb begin
        v = s1_item_reg.sample_value;
        if (cur_word.fill == '0) begin
            upd_min = v;
            upd_max = v;
        end else begin
            upd_min = (v < cur_word.bin_min) ? v : cur_word.bin_min;
            upd_max = (v > cur_word.bin_max) ? v : cur_word.bin_max;
        end
        mag_min = upd_min[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {upd_min[SAMPLE_W-1], upd_min})
                                      : {1'b0, upd_min};
        mag_max = upd_max[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {upd_max[SAMPLE_W-1], upd_max})
                                      : {1'b0, upd_max};
        peak_value = (mag_min > mag_max) ? upd_min : upd_max;

        fill_inc  = {1'b0, cur_word.fill} + (FILL_W+1)'(1);
        close_bin = (fill_inc >= factor_eff) || s1_item_reg.block_end;

        wr_word.bin_min = upd_min;
        wr_word.bin_max = upd_max;
        wr_word.fill    = close_bin ? '0 : fill_inc[FILL_W-1:0];

        emit = peak ? close_bin : (cur_word.fill == '0);

        out_item_next.out_channel   = s1_item_reg.channel;
        out_item_next.out_value     = peak ? peak_value : v;
        out_item_next.channel_class = cls;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && emit) begin
            out_item_reg <= out_item_next;
        end
    end

    // An accepted sample reaches the input register.
    `ASSERT_CLK(a_accept_loads, s_fire |=> s1_valid_reg, "accepted sample lost")
    // A stored fill always stays below the factor in force.
    `ASSERT_CLK(a_fill_below_factor, s1_fire |-> ({1'b0, wr_word.fill} < factor_eff), "fill reached factor")
    // A pick-first sample that opens a bin always gives a point.
    `ASSERT_CLK(a_first_emits, (s1_fire && !peak && (cur_word.fill == '0)) |=> m_valid, "first sample not emitted")

endmodule

[verif/tb_peak_preserving_channel_decimator.sv]
`timescale 1ns / 1ps

module tb_peak_preserving_channel_decimator;
    import ppcd_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 12;
    localparam int MAX_GAP         = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int SAMPLE_TARGET   = 500;
    localparam int REPORT_LIMIT    = 10;

    // Tracks the per-channel bins and the points they are due to emit.
    class bin_point_predictor;
        bit [BOUND_W-1:0]           neural_end;
        bit [BOUND_W-1:0]           analog_end;
        bit [FACTOR_W-1:0]          factor = 1;
        bit [FILL_W-1:0]            fill [MAX_CHANNELS];
        logic signed [SAMPLE_W-1:0] bin_lo [MAX_CHANNELS];
        logic signed [SAMPLE_W-1:0] bin_hi [MAX_CHANNELS];
        out_item_t                  expected_points [$];
        int                         mismatches;

        function void write_reg(cfg_reg_t idx, logic [FACTOR_W-1:0] data);
            case (idx)
                REG_NEURAL_END: neural_end = data[BOUND_W-1:0];
                REG_ANALOG_END: analog_end = data[BOUND_W-1:0];
                REG_FACTOR:     factor = data;
                default: ;
            endcase
        endfunction

        function void note_sample(in_item_t smp);
            int          ch;
            int          eff;
            int          next_fill;
            int          lo_mag;
            int          hi_mag;
            chan_class_t cls;
            bit          peak;
            bit          emit;
            out_item_t   pt;
            ch = int'(smp.channel);

            // A zero factor acts as one; the fill counter caps it at the maximum.
            eff = int'(factor);
            if (eff == 0) eff = 1;
            if (eff > int'(FACTOR_MAX)) eff = int'(FACTOR_MAX);

            if (ch < int'(neural_end)) cls = CLASS_NEURAL;
            else if (ch < int'(analog_end)) cls = CLASS_ANALOG;
            else cls = CLASS_DIGITAL;
            peak = (cls == CLASS_NEURAL) && (eff > 1);

            // Extremes are kept for every class, so a class change keeps them.
            if (fill[ch] == 0) begin
                bin_lo[ch] = smp.sample_value;
                bin_hi[ch] = smp.sample_value;
            end else begin
                if (smp.sample_value < bin_lo[ch]) bin_lo[ch] = smp.sample_value;
                if (smp.sample_value > bin_hi[ch]) bin_hi[ch] = smp.sample_value;
            end

            pt.out_channel   = smp.channel;
            pt.channel_class = cls;
            pt.out_value     = smp.sample_value;
            emit = !peak && (fill[ch] == 0);

            // The bin closes when full or at the end of a block.
            next_fill = int'(fill[ch]) + 1;
            if (next_fill >= eff || smp.block_end) begin
                if (peak) begin
                    lo_mag = (bin_lo[ch] < 0) ? -int'(bin_lo[ch]) : int'(bin_lo[ch]);
                    hi_mag = (bin_hi[ch] < 0) ? -int'(bin_hi[ch]) : int'(bin_hi[ch]);
                    pt.out_value = (lo_mag > hi_mag) ? bin_lo[ch] : bin_hi[ch];
                    emit = 1'b1;
                end
                fill[ch] = '0;
            end else begin
                fill[ch] = FILL_W'(next_fill);
            end

            if (emit) expected_points.push_back(pt);
        endfunction

        function void check_point(out_item_t got);
            out_item_t want;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected point ch %0d value %0d class %0d",
                             got.out_channel, $signed(got.out_value), got.channel_class);
                return;
            end
            want = expected_points.pop_front();
            if (want.out_channel !== got.out_channel || want.out_value !== got.out_value ||
                want.channel_class !== got.channel_class) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: expected ch %0d value %0d class %0d, got ch %0d value %0d class %0d",
                             want.out_channel, $signed(want.out_value), want.channel_class,
                             got.out_channel, $signed(got.out_value), got.channel_class);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FACTOR_W-1:0]  cfg_data = '0;

    bin_point_predictor   sb;
    bit                   sender_steady = 1'b0;
    bit                   hold_off_req = 1'b0;
    bit                   hold_off_done = 1'b0;
    int                   samples_sent = 0;
    int                   idle_cycles = 0;

    peak_preserving_channel_decimator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Offers one sample after a random gap, or none when steady, and waits for its transfer.
    task automatic send_sample(input int ch, input int val, input bit last);
        int       gap;
        in_item_t smp;
        gap = sender_steady ? 0 : int'($urandom_range(0, MAX_GAP));
        smp.channel      = CH_W'(ch);
        smp.sample_value = SAMPLE_W'(val);
        smp.block_end    = last;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_sample(smp);
        samples_sent++;
    endtask

    // Stops offering and lets the pipeline empty, including samples with no point.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Valid is left high so back-to-back writes need no second assignment.
    task automatic load_reg(input cfg_reg_t idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= FACTOR_W'(data);
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.write_reg(idx, FACTOR_W'(data));
    endtask

    task automatic configure(input int neural, input int analog, input int factor);
        load_reg(REG_NEURAL_END, neural);
        load_reg(REG_ANALOG_END, analog);
        load_reg(REG_FACTOR, factor);
        cfg_valid <= 1'b0;
    endtask

    // Favors full-scale values and small ones that produce magnitude ties.
    function automatic int pick_value();
        case ($urandom_range(0, 7))
            0:       return 32767;
            1:       return -32768;
            2:       return int'($urandom_range(0, 6)) - 3;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int draw_bound();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return MAX_CHANNELS;
            2:       return 127;
            default: return int'($urandom_range(0, MAX_CHANNELS));
        endcase
    endfunction

    function automatic int draw_factor();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return 255;
            3:       return 256;
            4:       return int'($urandom_range(257, 511));
            default: return int'($urandom_range(2, 12));
        endcase
    endfunction

    // A well-formed interleaved scan: channels in order, block end on the last round.
    task automatic send_scan(input int max_items);
        int nch;
        int base;
        int rounds;
        nch    = ($urandom_range(0, 7) == 0) ? MAX_CHANNELS : int'($urandom_range(1, 8));
        base   = int'($urandom_range(0, MAX_CHANNELS - 1));
        rounds = int'($urandom_range(1, 24));
        if (nch * rounds > max_items) rounds = (max_items / nch > 0) ? max_items / nch : 1;
        for (int r = 0; r < rounds; r++) begin
            for (int k = 0; k < nch; k++) begin
                send_sample((base + k) % MAX_CHANNELS, pick_value(), r == rounds - 1);
            end
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count) begin
            send_sample(int'($urandom_range(0, MAX_CHANNELS - 1)), pick_value(),
                        $urandom_range(0, 7) == 0);
        end
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off on request.
    initial begin
        int gap;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 32 == 0) steady = ($urandom_range(0, 2) == 0);
            if (hold_off_req && !hold_off_done) begin
                gap = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
            end else begin
                gap = steady ? 0 : int'($urandom_range(0, MAX_GAP));
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sb.check_point(m_data);
            taken++;
        end
    end

    // Ends the run when no transfer happens on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL peak_preserving_channel_decimator");
            $finish;
        end
    end

    initial begin
        sb = new;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: every channel digital, one sample per bin.
        load_reg(REG_UNUSED, 511);
        cfg_valid <= 1'b0;
        send_sample(0, 32767, 1'b0);
        send_sample(63, -32768, 1'b1);
        send_sample(5, 0, 1'b0);
        drain();

        // Zero factor acts as one, so neural channels also pick the first sample.
        configure(4, 8, 0);
        send_sample(1, -5, 1'b0);
        send_sample(6, 100, 1'b0);
        send_sample(20, 7, 1'b0);
        drain();

        // Peak bins: a magnitude tie goes to the maximum, then a partial bin.
        configure(64, 64, 3);
        send_sample(2, 10, 1'b0);
        send_sample(2, -10, 1'b0);
        send_sample(2, 3, 1'b0);
        send_sample(3, -32768, 1'b0);
        send_sample(3, 32767, 1'b0);
        send_sample(3, 0, 1'b0);
        send_sample(2, 5, 1'b0);
        send_sample(2, -9, 1'b1);
        drain();

        // Oversized factors are capped; all-ones bounds make every channel neural.
        configure(0, 64, 300);
        send_sample(9, 1, 1'b0);
        send_sample(9, 2, 1'b1);
        drain();
        configure(127, 127, 511);
        send_sample(63, -4, 1'b0);
        send_sample(63, 4, 1'b1);
        drain();

        // Factor lowered in the middle of a bin closes it on the next sample.
        configure(64, 64, 8);
        send_sample(7, 1, 1'b0);
        send_sample(7, 2, 1'b0);
        send_sample(7, 5, 1'b0);
        drain();
        configure(64, 64, 2);
        send_sample(7, -100, 1'b0);
        drain();

        // A digital bin turns neural halfway and closes with all its extremes.
        configure(0, 0, 4);
        send_sample(8, 50, 1'b0);
        send_sample(8, -60, 1'b0);
        drain();
        configure(16, 16, 4);
        send_sample(8, 20, 1'b0);
        send_sample(8, 1, 1'b0);
        send_sample(9, 3, 1'b0);
        drain();
        configure(0, 16, 4);
        send_sample(9, -3, 1'b1);
        drain();

        // Hold off the result side while the input keeps offering samples.
        configure(0, 0, 1);
        sender_steady = 1'b1;
        hold_off_req  = 1'b1;
        send_noise(80);
        drain();
        sender_steady = 1'b0;

        // Random phases: mostly interleaved scans, some unordered noise.
        while (samples_sent < SAMPLE_TARGET) begin
            configure(draw_bound(), draw_bound(), draw_factor());
            sender_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 4) != 0) send_scan(60);
                else send_noise(int'($urandom_range(5, 20)));
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
            $display("PASS peak_preserving_channel_decimator");
        end else begin
            $display("FAIL peak_preserving_channel_decimator");
        end
        $finish;
    end

endmodule
